// ===== design/gtsig_pkg.sv =====
// shared types and constants of the grid triangle strip index generator
// no dependencies
package gtsig_pkg;

	// largest grid dimension in vertices
	localparam int MAX_DIM = 1024;
	// width of a position or band count inside the grid
	localparam int POS_W = $clog2(MAX_DIM);
	// width of a dimension value, up to and including MAX_DIM
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	// fixed field widths
	localparam int IDX_W = 20;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

	// walk phase within a column
	typedef enum logic [1:0] {
		PH_UPPER = 2'd0,
		PH_LOWER = 2'd1,
		PH_TURN = 2'd2
	} phase_t;

	// effective grid shape, already saturated into range
	typedef struct packed {
		logic [DIM_W-1:0] cols;
		logic [POS_W-1:0] cols_m1;
		logic [POS_W-1:0] bands;
	} cfg_t;

	// one result word
	typedef struct packed {
		logic [IDX_W-1:0] vertex_index;
		logic is_degenerate;
		logic last;
	} result_t;

	// walk position, visible for checking
	typedef struct packed {
		logic [POS_W-1:0] band;
		logic [POS_W-1:0] pos;
		phase_t phase;
	} walk_state_t;

endpackage

// ===== design/grid_triangle_strip_index_gen_top.sv =====
// top level of the grid triangle strip index generator
// depends on gtsig_pkg and gtsig_walk
//
// Each word taken on the slave stream (s_tdata bit 0 = restart) yields one
// vertex index on the master stream. The strip covers a grid of columns x
// rows vertices band by band in serpentine order; m_tuser marks the
// degenerate turn vertex between bands and m_tlast marks the final index,
// after which the walk starts again from index 0.
// The result of an accepted word is registered in the output register;
// one word is accepted every cycle while the receiver is not stalling, set
// by the single walk update between the walk registers and the output register.
// s_tready is high while the output register is empty or being emptied, so
// a stalled receiver holds the result and back-pressures the input.
// The configuration channel writes columns (index 0) or rows (index 1);
// out-of-range values saturate and any write to either restarts the strip.
// After reset the grid is 2 x 2 and the walk sits at the first index.
module grid_triangle_strip_index_gen_top (
	input logic clk,
	input logic arst_n,
	// slave stream
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // [0] restart, [7:1] zero
	// master stream
	output logic m_tvalid,
	input logic m_tready,
	output logic [23:0] m_tdata, // [19:0] vertex_index, [23:20] zero
	output logic [0:0] m_tuser, // [0] is_degenerate
	output logic m_tlast,
	// configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [gtsig_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [gtsig_pkg::CFG_W-1:0] cfg_data
);

	gtsig_pkg::cfg_t cfg_q;
	gtsig_pkg::result_t res;
	gtsig_pkg::result_t out_q;
	gtsig_pkg::walk_state_t st;
	logic out_valid_q;
	logic in_acc;
	logic cfg_wr;
	logic cfg_hit;
	logic [gtsig_pkg::DIM_W-1:0] cols_sat;
	logic [gtsig_pkg::DIM_W-1:0] rows_sat;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign cfg_hit = cfg_wr
		&& ((cfg_index == gtsig_pkg::REG_COLUMNS) || (cfg_index == gtsig_pkg::REG_ROWS));

	// saturate written values into the supported grid range
	always_comb begin
		if (cfg_data == '0)
			cols_sat = gtsig_pkg::DIM_W'(1);
		else if (cfg_data > gtsig_pkg::CFG_W'(gtsig_pkg::MAX_DIM))
			cols_sat = gtsig_pkg::DIM_W'(gtsig_pkg::MAX_DIM);
		else
			cols_sat = gtsig_pkg::DIM_W'(cfg_data);
		if (cfg_data < gtsig_pkg::CFG_W'(2))
			rows_sat = gtsig_pkg::DIM_W'(2);
		else if (cfg_data > gtsig_pkg::CFG_W'(gtsig_pkg::MAX_DIM))
			rows_sat = gtsig_pkg::DIM_W'(gtsig_pkg::MAX_DIM);
		else
			rows_sat = gtsig_pkg::DIM_W'(cfg_data);
	end

	// grid shape registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols <= gtsig_pkg::DIM_W'(2);
			cfg_q.cols_m1 <= gtsig_pkg::POS_W'(1);
			cfg_q.bands <= gtsig_pkg::POS_W'(1);
		end else if (cfg_wr) begin
			if (cfg_index == gtsig_pkg::REG_COLUMNS) begin
				cfg_q.cols <= cols_sat;
				cfg_q.cols_m1 <= gtsig_pkg::POS_W'(cols_sat - 1'b1);
			end else if (cfg_index == gtsig_pkg::REG_ROWS) begin
				cfg_q.bands <= gtsig_pkg::POS_W'(rows_sat - 1'b1);
			end
		end
	end

	// input handshake: take a word whenever the output register frees up
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc = s_tvalid && s_tready;

	gtsig_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.adv(in_acc),
		.restart(s_tdata[0]),
		.clr(cfg_hit),
		.cfg(cfg_q),
		.res(res),
		.st(st)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, out_q.vertex_index};
	assign m_tuser = out_q.is_degenerate;
	assign m_tlast = out_q.last;

	// a turn vertex is never the final one
	a_degen_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tlast))
		else $error("degenerate index flagged as last");

	// the final index returns the walk to the start of the strip
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res.last && !cfg_hit) |=>
		(st.band == '0 && st.pos == '0 && st.phase == gtsig_pkg::PH_UPPER))
		else $error("walk not rewound after final index");

	// a register write restarts the strip
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (st.band == '0 && st.pos == '0 && st.phase == gtsig_pkg::PH_UPPER))
		else $error("walk not cleared by register write");

	// after a turn vertex the walk is on the upper vertex of a new band
	a_turn_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && res.is_degenerate && !cfg_hit) |=>
		(st.phase == gtsig_pkg::PH_UPPER && st.pos == '0 && st.band != '0))
		else $error("walk did not advance band after turn");

endmodule

// ===== design/gtsig_walk.sv =====
// serpentine walk counters and index arithmetic for one strip
// depends on gtsig_pkg
module gtsig_walk (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic restart,
	input logic clr,
	input gtsig_pkg::cfg_t cfg,
	output gtsig_pkg::result_t res,
	output gtsig_pkg::walk_state_t st
);

	logic [gtsig_pkg::POS_W-1:0] band_q;
	logic [gtsig_pkg::POS_W-1:0] pos_q;
	logic [gtsig_pkg::IDX_W-1:0] base_q;
	gtsig_pkg::phase_t phase_q;

	logic fresh;
	logic [gtsig_pkg::POS_W-1:0] band_c;
	logic [gtsig_pkg::POS_W-1:0] pos_c;
	logic [gtsig_pkg::IDX_W-1:0] base_c;
	gtsig_pkg::phase_t phase_c;
	logic [gtsig_pkg::POS_W-1:0] col;
	logic [gtsig_pkg::IDX_W-1:0] upper;
	logic [gtsig_pkg::IDX_W-1:0] lower;
	logic more_cols;
	logic more_bands;

	logic [gtsig_pkg::POS_W-1:0] band_d;
	logic [gtsig_pkg::POS_W-1:0] pos_d;
	logic [gtsig_pkg::IDX_W-1:0] base_d;
	gtsig_pkg::phase_t phase_d;

	// restart request or a position outside the grid starts a fresh strip
	assign fresh = restart
		|| ({1'b0, pos_q} >= cfg.cols)
		|| (band_q >= cfg.bands);

	assign band_c = fresh ? '0 : band_q;
	assign pos_c = fresh ? '0 : pos_q;
	assign base_c = fresh ? '0 : base_q;
	assign phase_c = fresh ? gtsig_pkg::PH_UPPER : phase_q;

	// odd bands run right to left
	assign col = band_c[0] ? (cfg.cols_m1 - pos_c) : pos_c;
	assign upper = base_c + gtsig_pkg::IDX_W'(col);
	assign lower = upper + gtsig_pkg::IDX_W'(cfg.cols);
	assign more_cols = pos_c != cfg.cols_m1;
	assign more_bands = ({1'b0, band_c} + 1'b1) < {1'b0, cfg.bands};

	// result and next walk position
	always_comb begin
		res.vertex_index = upper;
		res.is_degenerate = 1'b0;
		res.last = 1'b0;
		band_d = band_c;
		pos_d = pos_c;
		base_d = base_c;
		phase_d = phase_c;
		case (phase_c)
			gtsig_pkg::PH_LOWER: begin
				res.vertex_index = lower;
				if (more_cols) begin
					pos_d = pos_c + 1'b1;
					phase_d = gtsig_pkg::PH_UPPER;
				end else if (more_bands) begin
					phase_d = gtsig_pkg::PH_TURN;
				end else begin
					res.last = 1'b1;
					band_d = '0;
					pos_d = '0;
					base_d = '0;
					phase_d = gtsig_pkg::PH_UPPER;
				end
			end
			gtsig_pkg::PH_TURN: begin
				res.is_degenerate = 1'b1;
				band_d = band_c + 1'b1;
				base_d = base_c + gtsig_pkg::IDX_W'(cfg.cols);
				pos_d = '0;
				phase_d = gtsig_pkg::PH_UPPER;
			end
			default: begin
				phase_d = gtsig_pkg::PH_LOWER;
			end
		endcase
	end

	// walk state registers, cleared by a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
			pos_q <= '0;
			base_q <= '0;
			phase_q <= gtsig_pkg::PH_UPPER;
		end else if (clr) begin
			band_q <= '0;
			pos_q <= '0;
			base_q <= '0;
			phase_q <= gtsig_pkg::PH_UPPER;
		end else if (adv) begin
			band_q <= band_d;
			pos_q <= pos_d;
			base_q <= base_d;
			phase_q <= phase_d;
		end
	end

	assign st.band = band_q;
	assign st.pos = pos_q;
	assign st.phase = phase_q;

endmodule
